[hw/rtl/brsb_pkg.sv]
package brsb_pkg;

  localparam int unsigned MAX_ROW_BYTES = 64;

  localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME  = 64'h00000100000001b3;
  localparam logic [63:0] MIX_K1     = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_K2     = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned MIX_SHIFT  = 33;
  localparam logic [3:0]  HASH_LIMIT = 4'd8;

  // remainder digits per cycle in the modulo unit
  localparam int unsigned MOD_DIGITS = 4;
  localparam int unsigned MOD_STEPS  = 64 / MOD_DIGITS;

  localparam int unsigned ROW_BITS_W  = 10;
  localparam int unsigned HASH_CNT_W  = 4;
  localparam int unsigned THRESH_W    = 15;
  localparam int unsigned CFG_DATA_W  = 15;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [ROW_BITS_W-1:0] ROW_BITS_RST  = 10'd512;
  localparam logic [HASH_CNT_W-1:0] HASH_CNT_RST  = 4'd2;
  localparam logic [THRESH_W-1:0]   THRESH_RST    = 15'd1638;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_BITS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HASH_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD  = 2'd2;

endpackage

[hw/rtl/brsb_ram.sv]
module brsb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = brsb_pkg::MAX_ROW_BYTES,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bloom_row_sketch_builder_top.sv]
// A dropped weight (not kept, not last) leaves the block idle; the next transfer can follow at once.
// A kept weight stalls the input while H = min(hash_count, 8) hashes run: one shared 32x32
// multiplier builds each 64-bit product from three partial products, then modulo reduction.
// End of row: each sketch byte goes via the bitmap RAM read port, then waits on out_stall_i.
// Reset: asynchronous, active low; config takes its reset values and the per-byte valid flags
// clear, so the bitmap reads as zero at once with no clearing pass.
module bloom_row_sketch_builder_top #(
  parameter int unsigned MAX_ROW_BYTES = brsb_pkg::MAX_ROW_BYTES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [brsb_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [brsb_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [15:0]                        column_i,
  input  logic signed [15:0]                 weight_i,
  input  logic                               last_in_row_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [7:0]                         sketch_byte_o,
  output logic [5:0]                         byte_index_o,
  output logic                               last_byte_o
);

  localparam int unsigned AW   = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int unsigned BW   = $clog2(MAX_ROW_BYTES + 1);
  localparam int unsigned RW   = BW + 3;
  localparam int unsigned CMPW = (BW > 7) ? BW : 7;
  localparam int unsigned MCW  = $clog2(brsb_pkg::MOD_STEPS);
  localparam int unsigned DIG  = brsb_pkg::MOD_DIGITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HASH = 4'd1;
  localparam logic [3:0] S_MOD  = 4'd2;
  localparam logic [3:0] S_BRD  = 4'd3;
  localparam logic [3:0] S_BWR  = 4'd4;
  localparam logic [3:0] S_ERD  = 4'd5;
  localparam logic [3:0] S_ELD  = 4'd6;
  localparam logic [3:0] S_EOUT = 4'd7;

  localparam logic [2:0] STG_BASE = 3'd0;
  localparam logic [2:0] STG_MP   = 3'd1;
  localparam logic [2:0] STG_XS1  = 3'd2;
  localparam logic [2:0] STG_MK1  = 3'd3;
  localparam logic [2:0] STG_XS2  = 3'd4;
  localparam logic [2:0] STG_MK2  = 3'd5;
  localparam logic [2:0] STG_XS3  = 3'd6;

  localparam logic [1:0] MPH_LL  = 2'd0;
  localparam logic [1:0] MPH_LH  = 2'd1;
  localparam logic [1:0] MPH_HL  = 2'd2;
  localparam logic [1:0] MPH_SUM = 2'd3;

  // config registers
  logic [brsb_pkg::ROW_BITS_W-1:0] row_bits_q;
  logic [brsb_pkg::HASH_CNT_W-1:0] hash_count_q;
  logic [brsb_pkg::THRESH_W-1:0]   thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bits_q   <= brsb_pkg::ROW_BITS_RST;
      hash_count_q <= brsb_pkg::HASH_CNT_RST;
      thresh_q     <= brsb_pkg::THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        brsb_pkg::REG_ROW_BITS:   row_bits_q   <= cfg_wdata_i[brsb_pkg::ROW_BITS_W-1:0];
        brsb_pkg::REG_HASH_COUNT: hash_count_q <= cfg_wdata_i[brsb_pkg::HASH_CNT_W-1:0];
        brsb_pkg::REG_THRESHOLD:  thresh_q     <= cfg_wdata_i[brsb_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective row size
  logic [CMPW-1:0] rb_bytes;
  logic [BW-1:0]   nbytes;
  logic [RW-1:0]   nbits;

  always_comb begin
    rb_bytes = CMPW'(row_bits_q[brsb_pkg::ROW_BITS_W-1:3]);
    if (rb_bytes == '0) begin
      nbytes = BW'(1);
    end else if (rb_bytes > CMPW'(MAX_ROW_BYTES)) begin
      nbytes = BW'(MAX_ROW_BYTES);
    end else begin
      nbytes = BW'(rb_bytes);
    end
    nbits = {nbytes, 3'b000};
  end

  // input decode
  logic [16:0]                     mag;
  logic                            kept;
  logic [brsb_pkg::HASH_CNT_W-1:0] hc_sat;

  always_comb begin
    if (weight_i[15]) begin
      mag = 17'h10000 - {1'b0, weight_i};
    end else begin
      mag = {1'b0, weight_i};
    end
    kept   = mag > {2'b00, thresh_q};
    hc_sat = (hash_count_q > brsb_pkg::HASH_LIMIT) ? brsb_pkg::HASH_LIMIT : hash_count_q;
  end

  // sequencer and datapath registers
  logic [3:0]                      state_q, state_d;
  logic [2:0]                      stg_q, stg_d;
  logic [1:0]                      mph_q, mph_d;
  logic [brsb_pkg::HASH_CNT_W-1:0] h_q, h_d;
  logic [brsb_pkg::HASH_CNT_W-1:0] hc_q, hc_d;
  logic                            last_q, last_d;
  logic [63:0]                     x_q, x_d;
  logic [63:0]                     base_q, base_d;
  logic [63:0]                     acc_q, acc_d;
  logic [63:0]                     prod_q;
  logic [RW-1:0]                   r_q, r_d;
  logic [MCW-1:0]                  mc_q, mc_d;
  logic [BW-1:0]                   idx_q, idx_d;
  logic [MAX_ROW_BYTES-1:0]        vld_q, vld_d;
  logic                            out_valid_q, out_valid_d;
  logic [7:0]                      out_byte_q, out_byte_d;
  logic [5:0]                      out_idx_q, out_idx_d;
  logic                            out_last_q, out_last_d;

  // shared 32x32 multiplier
  logic [63:0] mul_k;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] mul_res;
  logic [63:0] xs_res;

  always_comb begin
    case (stg_q)
      STG_MK1: mul_k = brsb_pkg::MIX_K1;
      STG_MK2: mul_k = brsb_pkg::MIX_K2;
      default: mul_k = brsb_pkg::FNV_PRIME;
    endcase
    unique case (mph_q)
      MPH_LH: begin
        mul_a = x_q[31:0];
        mul_b = mul_k[63:32];
      end
      MPH_HL: begin
        mul_a = x_q[63:32];
        mul_b = mul_k[31:0];
      end
      default: begin
        mul_a = x_q[31:0];
        mul_b = mul_k[31:0];
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign mul_res = acc_q + {prod_q[31:0], 32'd0};
  assign xs_res  = x_q ^ (x_q >> brsb_pkg::MIX_SHIFT);

  // modulo unit: DIG restoring steps per cycle
  logic [RW-1:0] rem_next;

  always_comb begin
    logic [RW:0]   t;
    logic [RW-1:0] rem;
    rem = r_q;
    for (int j = 0; j < DIG; j++) begin
      t = {rem, x_q[63-j]};
      if (t >= {1'b0, nbits}) begin
        t = t - {1'b0, nbits};
      end
      rem = t[RW-1:0];
    end
    rem_next = rem;
  end

  // bitmap RAM
  logic [AW-1:0] byte_addr;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic [7:0]    ram_wdata;
  logic          ram_we;

  assign byte_addr = r_q[AW+2:3];
  assign ram_raddr = (state_q == S_BRD) ? byte_addr : idx_q[AW-1:0];
  assign ram_we    = (state_q == S_BWR);
  assign ram_wdata = (vld_q[byte_addr] ? ram_rdata : 8'd0) | (8'd1 << r_q[2:0]);

  brsb_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (byte_addr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = in_valid_i && (state_q == S_IDLE);
  assign out_xfer = out_valid_q && !out_stall_i;

  always_comb begin
    state_d     = state_q;
    stg_d       = stg_q;
    mph_d       = mph_q;
    h_d         = h_q;
    hc_d        = hc_q;
    last_d      = last_q;
    x_d         = x_q;
    base_d      = base_q;
    acc_d       = acc_q;
    r_d         = r_q;
    mc_d        = mc_q;
    idx_d       = idx_q;
    vld_d       = vld_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          last_d = last_in_row_i;
          hc_d   = hc_sat;
          h_d    = '0;
          idx_d  = '0;
          if (kept && (hc_sat != '0)) begin
            x_d     = brsb_pkg::FNV_OFFSET ^ {48'd0, column_i};
            stg_d   = STG_BASE;
            mph_d   = MPH_LL;
            state_d = S_HASH;
          end else if (last_in_row_i) begin
            state_d = S_ERD;
          end
        end
      end
      S_HASH: begin
        if (stg_q == STG_XS1 || stg_q == STG_XS2 || stg_q == STG_XS3) begin
          x_d = xs_res;
          if (stg_q == STG_XS3) begin
            r_d     = '0;
            mc_d    = '0;
            state_d = S_MOD;
          end else begin
            stg_d = stg_q + 3'd1;
          end
        end else begin
          mph_d = mph_q + 2'd1;
          unique case (mph_q)
            MPH_LL: ;
            MPH_LH: acc_d = prod_q;
            MPH_HL: acc_d = mul_res;
            MPH_SUM: begin
              if (stg_q == STG_BASE) begin
                base_d = mul_res;
                x_d    = mul_res ^ 64'(h_q);
              end else begin
                x_d = mul_res;
              end
              stg_d = stg_q + 3'd1;
            end
            default: ;
          endcase
        end
      end
      S_MOD: begin
        r_d  = rem_next;
        x_d  = x_q << DIG;
        mc_d = mc_q + MCW'(1);
        if (mc_q == MCW'(brsb_pkg::MOD_STEPS - 1)) begin
          state_d = S_BRD;
        end
      end
      S_BRD: begin
        state_d = S_BWR;
      end
      S_BWR: begin
        vld_d[byte_addr] = 1'b1;
        h_d = h_q + brsb_pkg::HASH_CNT_W'(1);
        if (h_q + brsb_pkg::HASH_CNT_W'(1) == hc_q) begin
          state_d = last_q ? S_ERD : S_IDLE;
        end else begin
          x_d     = base_q ^ 64'(h_q + brsb_pkg::HASH_CNT_W'(1));
          stg_d   = STG_MP;
          mph_d   = MPH_LL;
          state_d = S_HASH;
        end
      end
      S_ERD: begin
        state_d = S_ELD;
      end
      S_ELD: begin
        out_valid_d = 1'b1;
        out_byte_d  = vld_q[idx_q[AW-1:0]] ? ram_rdata : 8'd0;
        out_idx_d   = 6'(idx_q);
        out_last_d  = (idx_q + BW'(1) == nbytes);
        state_d     = S_EOUT;
      end
      S_EOUT: begin
        if (out_xfer) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            vld_d   = '0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + BW'(1);
            state_d = S_ERD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stg_q       <= STG_BASE;
      mph_q       <= MPH_LL;
      h_q         <= '0;
      hc_q        <= '0;
      last_q      <= 1'b0;
      mc_q        <= '0;
      idx_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stg_q       <= stg_d;
      mph_q       <= mph_d;
      h_q         <= h_d;
      hc_q        <= hc_d;
      last_q      <= last_d;
      mc_q        <= mc_d;
      idx_q       <= idx_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    base_q     <= base_d;
    acc_q      <= acc_d;
    prod_q     <= mul_p;
    r_q        <= r_d;
    out_byte_q <= out_byte_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign sketch_byte_o = out_byte_q;
  assign byte_index_o  = out_idx_q;
  assign last_byte_o   = out_last_q;

  a_out_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == S_EOUT))
    else $error("result valid outside emission");

  a_drop_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !kept && !last_in_row_i) |=> !in_stall_o)
    else $error("dropped weight held the input");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD || state_q == S_BWR) |-> (r_q < nbits))
    else $error("hash remainder out of range");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ELD) |-> (idx_q < nbytes))
    else $error("emission index past row end");

endmodule
